[hw/rtl/bdqs_pkg.sv]
// Shared types and codes for the bounded deque with search.
// No dependencies; bdqs_cell and the top level import this package.
`default_nettype none

package bdqs_pkg;

    localparam int OPCODE_W = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 5;

    typedef logic signed [WORD_W-1:0] word_t;

    // Command opcodes
    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_LIST       = 3'd4;
    localparam logic [OPCODE_W-1:0] OP_SEARCH     = 3'd5;

    // Response status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Per-cell load selection
    localparam logic [2:0] CELL_HOLD  = 3'd0;
    localparam logic [2:0] CELL_LOAD  = 3'd1;
    localparam logic [2:0] CELL_LEFT  = 3'd2;
    localparam logic [2:0] CELL_RIGHT = 3'd3;
    localparam logic [2:0] CELL_WRAP  = 3'd4;

    typedef struct packed {
        logic [2:0] op;
    } cell_ctrl_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        word_t               value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        word_t               item;
        logic [POS_W-1:0]    position;
        logic                last;
    } rsp_t;

endpackage

`default_nettype wire

[hw/rtl/bdqs_stream_if.sv]
// Valid/ready stream interface carrying one payload word per handshake.
// Payload type is set by the instantiating scope; no package dependency.
`default_nettype none

interface bdqs_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/bdqs_cell.sv]
// One storage cell of the deque chain: a word register and its load select.
// Depends on bdqs_pkg.
`default_nettype none

module bdqs_cell (
    input  wire logic               clk,
    input  wire bdqs_pkg::cell_ctrl_t ctrl,
    input  wire bdqs_pkg::word_t    load_data,
    input  wire bdqs_pkg::word_t    left_data,
    input  wire bdqs_pkg::word_t    right_data,
    input  wire bdqs_pkg::word_t    wrap_data,
    output bdqs_pkg::word_t         data
);
    import bdqs_pkg::*;

    word_t data_reg;
    word_t data_next;

    always_comb
    begin
        case (ctrl.op)
            CELL_LOAD:  data_next = load_data;
            CELL_LEFT:  data_next = left_data;
            CELL_RIGHT: data_next = right_data;
            CELL_WRAP:  data_next = wrap_data;
            default:    data_next = data_reg;
        endcase
    end

    // payload only: no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

[hw/rtl/bounded_deque_with_search_unit.sv]
// Top level of the bounded deque with linear search: control, walk counter,
// response register and the chain of bdqs_cell. Depends on bdqs_pkg,
// bdqs_stream_if and bdqs_cell.
//
//   channel | dir | payload                              | handshake
//   --------+-----+--------------------------------------+-------------
//   cmd     | in  | opcode[2:0], value[31:0]             | valid/ready
//   rsp     | out | status[1:0], item[31:0], position[4:0], last | valid/ready
//
// Push, pop and unused opcodes are handled when the command word is accepted.
// List and search accept the command word and then walk the stored words one
// per cycle while the response is taken, rotating the cell chain through cell
// 0; no new command word is taken until the walk ends.
// Reset clears the fill count, state and response valid; the cells are not
// cleared, since only live cells are ever read.
// A stalled response holds the walk; a new command is taken in the same
// cycle as the previous response leaves the output register.
`default_nettype none

module bounded_deque_with_search_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bdqs_stream_if.sink   cmd,
    bdqs_stream_if.source rsp
);
    import bdqs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_WALK = 1'b1;

    // chain actions for one cycle
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd2;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [2:0] ACT_ROTATE     = 3'd4;

    logic [0:0]       state_reg,   state_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [CNT_W-1:0] idx_reg,     idx_next;
    logic             search_reg,  search_next;
    logic             found_reg,   found_next;
    logic [POS_W-1:0] hit_pos_reg, hit_pos_next;
    word_t            key_reg,     key_next;
    logic             out_valid_reg, out_valid_next;
    rsp_t             rsp_reg,     rsp_next;

    cmd_t             cmd_word;
    logic             out_free;
    logic             accept;
    logic [2:0]       act;
    logic [CNT_W-1:0] walk_pos;
    logic             walk_final;
    logic             hit;

    word_t            cell_data [DEPTH];
    cell_ctrl_t       cell_ctrl [DEPTH];

    assign cmd_word  = cmd.payload;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign cmd.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = cmd.valid && cmd.ready;

    assign walk_pos   = idx_reg + CNT_W'(1);
    assign walk_final = (walk_pos == count_reg);
    assign hit        = !found_reg && (cell_data[0] == key_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        search_next    = search_reg;
        found_next     = found_reg;
        hit_pos_next   = hit_pos_reg;
        key_next       = key_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        rsp_next       = rsp_reg;
        act            = ACT_NONE;

        if (accept)
        begin
            rsp_next.item     = '0;
            rsp_next.position = '0;
            rsp_next.last     = 1'b1;
            case (cmd_word.opcode)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        rsp_next.status = ST_FULL;
                    end
                    else
                    begin
                        rsp_next.status = ST_OK;
                        count_next      = count_reg + CNT_W'(1);
                        act = (cmd_word.opcode == OP_PUSH_FRONT) ? ACT_PUSH_FRONT
                                                                 : ACT_PUSH_BACK;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK:
                begin
                    out_valid_next = 1'b1;
                    if (count_reg == '0)
                    begin
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        rsp_next.status = ST_OK;
                        count_next      = count_reg - CNT_W'(1);
                        if (cmd_word.opcode == OP_POP_FRONT)
                        begin
                            act = ACT_POP_FRONT;
                        end
                    end
                end
                OP_LIST, OP_SEARCH:
                begin
                    if (count_reg == '0)
                    begin
                        out_valid_next  = 1'b1;
                        rsp_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        state_next  = S_WALK;
                        idx_next    = '0;
                        search_next = (cmd_word.opcode == OP_SEARCH);
                        found_next  = 1'b0;
                        key_next    = cmd_word.value;
                    end
                end
                default:
                begin
                    // unused opcode: drop the word, no response
                end
            endcase
        end
        else if ((state_reg == S_WALK) && out_free)
        begin
            // advance the ring by one: cell 0 goes out and wraps to the tail
            act      = ACT_ROTATE;
            idx_next = walk_pos;
            if (!search_reg)
            begin
                out_valid_next    = 1'b1;
                rsp_next.status   = ST_OK;
                rsp_next.item     = cell_data[0];
                rsp_next.position = POS_W'(walk_pos);
                rsp_next.last     = walk_final;
            end
            else
            begin
                if (hit)
                begin
                    found_next   = 1'b1;
                    hit_pos_next = POS_W'(walk_pos);
                end
                if (walk_final)
                begin
                    out_valid_next  = 1'b1;
                    rsp_next.item   = '0;
                    rsp_next.last   = 1'b1;
                    if (found_reg || hit)
                    begin
                        rsp_next.status   = ST_OK;
                        rsp_next.position = found_reg ? hit_pos_reg : POS_W'(walk_pos);
                    end
                    else
                    begin
                        rsp_next.status   = ST_NOTFOUND;
                        rsp_next.position = '0;
                    end
                end
            end
            if (walk_final)
            begin
                state_next = S_IDLE;
            end
        end
    end

    // per-cell load select from the chain action
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            case (act)
                ACT_PUSH_FRONT:
                    cell_ctrl[i].op = (i == 0) ? CELL_LOAD : CELL_LEFT;
                ACT_PUSH_BACK:
                    cell_ctrl[i].op = (count_reg == CNT_W'(i)) ? CELL_LOAD : CELL_HOLD;
                ACT_POP_FRONT:
                    cell_ctrl[i].op = CELL_RIGHT;
                ACT_ROTATE:
                    if (count_reg == CNT_W'(i + 1))
                        cell_ctrl[i].op = CELL_WRAP;
                    else if (count_reg > CNT_W'(i))
                        cell_ctrl[i].op = CELL_RIGHT;
                    else
                        cell_ctrl[i].op = CELL_HOLD;
                default:
                    cell_ctrl[i].op = CELL_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        word_t left_w;
        word_t right_w;

        if (g == 0)
        begin : g_first
            assign left_w = cmd_word.value;
        end
        else
        begin : g_mid_l
            assign left_w = cell_data[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_end
            assign right_w = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_w = cell_data[g+1];
        end

        bdqs_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[g]),
            .load_data  (cmd_word.value),
            .left_data  (left_w),
            .right_data (right_w),
            .wrap_data  (cell_data[0]),
            .data       (cell_data[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            search_reg    <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            search_reg    <= search_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        hit_pos_reg <= hit_pos_next;
        key_reg     <= key_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = rsp_reg;

    // fill count never passes the bound
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    // no command is taken during a walk
    a_no_accept_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> !cmd.ready)
        else $error("command ready during walk");

    // a walk leaves the fill count alone
    a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |=> $stable(count_reg))
        else $error("fill count changed during walk");

    // only a list walk produces a non-final word
    a_last_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp_reg.last) |-> (state_reg == S_WALK) && !search_reg)
        else $error("non-final response outside list walk");

endmodule

`default_nettype wire
